FILE: rtl/core/rtsd_pkg.sv
// Shared types, constants and lookup functions for the relay and display frame block.
`default_nettype none
package rtsd_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned KEY_W      = 4;
  localparam int unsigned RELAY_W    = 4;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned NUM_DIGITS = 4;

  localparam logic [CFG_W-1:0]  DEBOUNCE_RST = 16'd200;
  localparam logic [CFG_W-1:0]  PERIOD_RST   = 16'd1000;
  localparam logic [SLOT_W-1:0] SLOT_FIRST   = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_LAST    = 3'd7;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 1'b0,
    CFG_PERIOD   = 1'b1
  } cfg_idx_e;

  // Display counter held as four BCD digits, index 0 is the units digit.
  typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

  // One display job handed from the front to the back.
  typedef struct packed {
    logic [RELAY_W-1:0] relay;
    bcd_t               digits;
  } job_t;

  // Decimal increment modulo 10000.
  function automatic bcd_t bcd_inc(input bcd_t val);
    bcd_t res;
    logic carry;
    res   = val;
    carry = 1'b1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (carry) begin
        if (val[i] >= 4'd9) begin
          res[i] = 4'd0;
        end else begin
          res[i] = val[i] + 4'd1;
          carry  = 1'b0;
        end
      end
    end
    return res;
  endfunction

  // Seven-segment pattern of a decimal digit.
  function automatic logic [BYTE_W-1:0] seg_code(input logic [3:0] d);
    logic [BYTE_W-1:0] p;
    case (d)
      4'd0:    p = 8'h3F;
      4'd1:    p = 8'h06;
      4'd2:    p = 8'h5B;
      4'd3:    p = 8'h4F;
      4'd4:    p = 8'h66;
      4'd5:    p = 8'h6D;
      4'd6:    p = 8'h7D;
      4'd7:    p = 8'h07;
      4'd8:    p = 8'h7F;
      4'd9:    p = 8'h6F;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  // Digit select byte by slot; odd slots select nothing.
  function automatic logic [BYTE_W-1:0] sel_code(input logic [SLOT_W-1:0] s);
    logic [BYTE_W-1:0] p;
    case (s)
      3'd0:    p = 8'hFE;
      3'd2:    p = 8'hFD;
      3'd4:    p = 8'hFB;
      3'd6:    p = 8'hF7;
      default: p = 8'hFF;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/rtsd_if.sv
// Valid/ready stream interfaces for the input and result channels.
`default_nettype none
interface rtsd_in_if;
  import rtsd_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] time_ms;
  logic [KEY_W-1:0]  keys_pressed;

  modport source (output valid, output time_ms, output keys_pressed, input ready);
  modport sink   (input valid, input time_ms, input keys_pressed, output ready);
endinterface

interface rtsd_out_if;
  import rtsd_pkg::*;
  logic               valid;
  logic               ready;
  logic [RELAY_W-1:0] relay_bits;
  logic [BYTE_W-1:0]  digit_select;
  logic [BYTE_W-1:0]  segment_pattern;
  logic [SLOT_W-1:0]  slot_index;
  logic               last_frame;

  modport source (output valid, output relay_bits, output digit_select,
                  output segment_pattern, output slot_index, output last_frame,
                  input ready);
  modport sink   (input valid, input relay_bits, input digit_select,
                  input segment_pattern, input slot_index, input last_frame,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/core/rtsd_front.sv
// Front end: accepts a word, updates relays and counter, and queues a display job.
`default_nettype none
module rtsd_front #(
  parameter int unsigned ACT_KEYS = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rtsd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rtsd_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rtsd_pkg::TIME_W-1:0]      in_time_ms,
  input  logic [rtsd_pkg::KEY_W-1:0]       in_keys,
  output logic                             push,
  input  logic                             full,
  output rtsd_pkg::job_t                   job
);
  import rtsd_pkg::*;

  logic [CFG_W-1:0]   debounce_r;
  logic [CFG_W-1:0]   period_r;
  logic [RELAY_W-1:0] relay_r, relay_nxt;
  logic [ACT_KEYS-1:0] key_was_r;
  logic [ACT_KEYS-1:0] toggle;
  logic [TIME_W-1:0]  last_toggle_r [ACT_KEYS];
  logic [TIME_W-1:0]  last_count_r;
  bcd_t               bcd_r, bcd_nxt;
  logic [TIME_W-1:0]  count_elapsed;
  logic               advance;

  assign in_ready = ~full;
  assign push     = in_valid & ~full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      period_r   <= PERIOD_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DEBOUNCE) begin
        debounce_r <= cfg_wdata;
      end else begin
        period_r <= cfg_wdata;
      end
    end
  end

  // Each key toggles its own relay bit on a debounced rising edge.
  always_comb begin
    logic [TIME_W-1:0] elapsed;
    relay_nxt = relay_r;
    toggle    = '0;
    for (int i = 0; i < ACT_KEYS; i++) begin
      elapsed = in_time_ms - last_toggle_r[i];
      if (in_keys[i] && !key_was_r[i] && (elapsed >= {{(TIME_W-CFG_W){1'b0}}, debounce_r})) begin
        relay_nxt[i] = ~relay_r[i];
        toggle[i]    = 1'b1;
      end
    end
  end

  // Display counter advance once the count period has elapsed.
  assign count_elapsed = in_time_ms - last_count_r;
  assign advance       = count_elapsed >= {{(TIME_W-CFG_W){1'b0}}, period_r};
  assign bcd_nxt       = advance ? bcd_inc(bcd_r) : bcd_r;

  assign job.relay  = relay_nxt;
  assign job.digits = bcd_nxt;

  // Loop state, updated on every accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_r      <= '0;
      key_was_r    <= '0;
      bcd_r        <= '0;
      last_count_r <= '0;
      for (int i = 0; i < ACT_KEYS; i++) begin
        last_toggle_r[i] <= '0;
      end
    end else if (push) begin
      relay_r   <= relay_nxt;
      key_was_r <= in_keys[ACT_KEYS-1:0];
      bcd_r     <= bcd_nxt;
      if (advance) begin
        last_count_r <= in_time_ms;
      end
      for (int i = 0; i < ACT_KEYS; i++) begin
        if (toggle[i]) begin
          last_toggle_r[i] <= in_time_ms;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/rtsd_fifo.sv
// Two-entry job queue between the front end and the frame sequencer.
`default_nettype none
module rtsd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rtsd_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output rtsd_pkg::job_t pop_data
);
  import rtsd_pkg::*;

  job_t       mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] count_r, count_nxt;

  assign full      = count_r[1];
  assign not_empty = count_r != 2'd0;
  assign pop_data  = mem_r[rptr_r];

  // Occupancy follows pushes and pops.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/rtsd_back.sv
// Back end: walks the eight display slots of a job into a registered output word.
`default_nettype none
module rtsd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_valid,
  input  rtsd_pkg::job_t                job_in,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rtsd_pkg::RELAY_W-1:0]  out_relay_bits,
  output logic [rtsd_pkg::BYTE_W-1:0]   out_digit_select,
  output logic [rtsd_pkg::BYTE_W-1:0]   out_segment_pattern,
  output logic [rtsd_pkg::SLOT_W-1:0]   out_slot_index,
  output logic                          out_last_frame
);
  import rtsd_pkg::*;

  job_t               job_r;
  logic               busy_r, busy_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [RELAY_W-1:0] relay_r;
  logic [BYTE_W-1:0]  sel_r;
  logic [BYTE_W-1:0]  seg_r;
  logic [SLOT_W-1:0]  oslot_r;
  logic               olast_r;
  logic               emit;
  logic               at_last;
  logic [3:0]         digit;

  assign emit    = busy_r & (~out_valid_r | out_ready);
  assign at_last = slot_r == SLOT_LAST;
  assign pop     = job_valid & (~busy_r | (emit & at_last));

  // Slot pair k shows digit 3-k, thousands first.
  assign digit = job_r.digits[~slot_r[SLOT_W-1:1]];

  // Sequencer and output register control.
  always_comb begin
    busy_nxt = busy_r;
    slot_nxt = slot_r;
    if (pop) begin
      busy_nxt = 1'b1;
      slot_nxt = SLOT_FIRST;
    end else if (emit) begin
      busy_nxt = ~at_last;
      slot_nxt = slot_r + 3'd1;
    end
    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      slot_r      <= SLOT_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Job and frame payload registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= job_in;
    end
    if (emit) begin
      relay_r <= job_r.relay;
      sel_r   <= sel_code(slot_r);
      seg_r   <= seg_code(digit);
      oslot_r <= slot_r;
      olast_r <= at_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_relay_bits      = relay_r;
  assign out_digit_select    = sel_r;
  assign out_segment_pattern = seg_r;
  assign out_slot_index      = oslot_r;
  assign out_last_frame      = olast_r;

endmodule
`default_nettype wire

FILE: rtl/core/relay_toggle_and_segment_display_frames_core.sv
// A word's job passes the queue, the back-end job register and the output register.
// Each word yields eight frames, one per slot, paced by the sequencer slot counter
// and held while out_ready is low; a two-entry job queue decouples input.
// Reset: synchronous active-low rst_n clears relays, key history, counter and queue,
// and sets debounce to 200 ms and count period to 1000 ms.
`default_nettype none
module relay_toggle_and_segment_display_frames_core #(
  parameter int unsigned NUM_KEYS = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rtsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rtsd_pkg::CFG_W-1:0]     cfg_wdata,
  rtsd_in_if.sink                        in_ch,
  rtsd_out_if.source                     out_ch
);
  import rtsd_pkg::*;

  // Only keys that exist on the input can toggle a relay.
  localparam int unsigned ACT_KEYS = (NUM_KEYS < KEY_W) ? NUM_KEYS : KEY_W;

  logic push, full, pop, not_empty;
  job_t push_job, pop_job;

  rtsd_front #(.ACT_KEYS(ACT_KEYS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_time_ms (in_ch.time_ms),
    .in_keys    (in_ch.keys_pressed),
    .push       (push),
    .full       (full),
    .job        (push_job)
  );

  rtsd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_job),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (pop_job)
  );

  rtsd_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .job_valid           (not_empty),
    .job_in              (pop_job),
    .pop                 (pop),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_relay_bits      (out_ch.relay_bits),
    .out_digit_select    (out_ch.digit_select),
    .out_segment_pattern (out_ch.segment_pattern),
    .out_slot_index      (out_ch.slot_index),
    .out_last_frame      (out_ch.last_frame)
  );

endmodule
`default_nettype wire

FILE: rtl/core/rtsd_checker.sv
// Port-level checker for the display frame block and its bind to the top level.
`default_nettype none
module rtsd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] relay_bits,
  input logic [7:0] digit_select,
  input logic [7:0] segment_pattern,
  input logic [2:0] slot_index,
  input logic       last_frame
);

  // A stalled result word holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(slot_index) && $stable(segment_pattern)
      && $stable(digit_select) && $stable(relay_bits))
    else $error("result word changed while stalled");

  // Back-to-back frames inside one run step through the slots in order.
  a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid && out_ready) && !$past(last_frame)
      |-> slot_index == $past(slot_index) + 3'd1)
    else $error("slot order broken inside a frame run");

  // Inside a run the relay bits hold and an odd slot repeats its even slot's digit.
  a_run_const: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid && out_ready) && !$past(last_frame)
      |-> relay_bits == $past(relay_bits)
        && (!slot_index[0] || segment_pattern == $past(segment_pattern)))
    else $error("frame run content inconsistent");

  // Coming out of reset no result is pending and input is taken.
  a_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind relay_toggle_and_segment_display_frames_core rtsd_checker u_rtsd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .relay_bits      (out_ch.relay_bits),
  .digit_select    (out_ch.digit_select),
  .segment_pattern (out_ch.segment_pattern),
  .slot_index      (out_ch.slot_index),
  .last_frame      (out_ch.last_frame)
);
`default_nettype wire
